// File: rtl/line_and_dot_stuffed_block_parser_top_defines.svh
// ----------------------------------------------------------------------------
// line and dot-stuffed block parser: assertion macros
// concurrent checks clocked on clk and disabled while rst is high
// ----------------------------------------------------------------------------
`ifndef LINE_AND_DOT_STUFFED_BLOCK_PARSER_TOP_DEFINES_SVH
`define LINE_AND_DOT_STUFFED_BLOCK_PARSER_TOP_DEFINES_SVH

// same-cycle implication
`define LDSBP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LDSBP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/ldsbp_pkg.sv
// ----------------------------------------------------------------------------
// ldsbp_pkg
// shared constants, types and helper functions of the line and dot-stuffed
// block parser
// ----------------------------------------------------------------------------
package ldsbp_pkg;

  localparam int SPACE_DEPTH = 16;
  localparam int SPACE_AW    = (SPACE_DEPTH > 1) ? $clog2(SPACE_DEPTH) : 1;
  localparam int SPACE_CW    = $clog2(SPACE_DEPTH + 1);

  // fixed results one request can carry, besides a whitespace flush
  localparam int EV_MAX = 4;
  localparam int EV_AW  = $clog2(EV_MAX);
  localparam int EV_CW  = $clog2(EV_MAX + 1);

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_A_LO  = 8'h61;
  localparam logic [7:0] CH_Z_LO  = 8'h7A;
  localparam logic [7:0] CASE_GAP = 8'h20;

  localparam logic [2:0] K_TAG  = 3'd0;
  localparam logic [2:0] K_DATA = 3'd1;
  localparam logic [2:0] K_BODY = 3'd2;
  localparam logic [2:0] K_LEND = 3'd3;
  localparam logic [2:0] K_BEND = 3'd4;
  localparam logic [2:0] K_MODE = 3'd5;

  typedef enum logic [1:0] {
    M_IDLE,
    M_TAG,
    M_TEXT,
    M_BODY
  } mode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEC,
    S_WR2,
    S_FPRE,
    S_FLUSH,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] out_byte;
    logic [7:0] raw_byte;
    logic       no_separator;
    logic       space_overflow;
    logic       accepted;
    logic       last;
  } res_t;

  typedef struct packed {
    logic latch;
    logic decode;
    logic wr2;
    logic fl_emit;
    logic ev_emit;
  } cmd_t;

  typedef struct packed {
    logic need_wr2;
    logic need_flush;
    logic has_ev;
    logic fl_end;
    logic ev_end;
    logic slot_free;
  } stat_t;

  function automatic logic is_ws(input logic [7:0] b);
    return (b == CH_SP) || (b == CH_TAB) || (b == CH_LF) || (b == CH_VT) ||
           (b == CH_FF) || (b == CH_CR);
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] b);
    return (b >= CH_A_LO && b <= CH_Z_LO) ? b - CASE_GAP : b;
  endfunction

  function automatic res_t mk_res(input logic [2:0] kind, input logic [7:0] ob,
                                  input logic [7:0] rb, input logic nosep,
                                  input logic ovf, input logic acc);
    res_t r;
    r.kind           = kind;
    r.out_byte       = ob;
    r.raw_byte       = rb;
    r.no_separator   = nosep;
    r.space_overflow = ovf;
    r.accepted       = acc;
    r.last           = 1'b0;
    return r;
  endfunction

endpackage

// File: rtl/ldsbp_in_if.sv
// ----------------------------------------------------------------------------
// ldsbp_in_if
// input channel: one stream byte or a data mode request per request
// ----------------------------------------------------------------------------
interface ldsbp_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] in_byte;

  modport source (output valid, output func, output in_byte, input ready);
  modport sink (input valid, input func, input in_byte, output ready);
endinterface

// File: rtl/ldsbp_out_if.sv
// ----------------------------------------------------------------------------
// ldsbp_out_if
// result channel: zero or more parsed results, in order, per request
// ----------------------------------------------------------------------------
interface ldsbp_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] out_byte;
  logic [7:0] raw_byte;
  logic       no_separator;
  logic       space_overflow;
  logic       accepted;
  logic       last;

  modport source (output valid, output kind, output out_byte, output raw_byte,
                  output no_separator, output space_overflow, output accepted,
                  output last, input ready);
  modport sink (input valid, input kind, input out_byte, input raw_byte,
                input no_separator, input space_overflow, input accepted,
                input last, output ready);
endinterface

// File: rtl/ldsbp_ctrl.sv
// ----------------------------------------------------------------------------
// ldsbp_ctrl
// sequencer: takes a request, lets the datapath decode it, then does a second
// store write or walks the whitespace flush and result list, one per free slot
// ----------------------------------------------------------------------------
module ldsbp_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  ldsbp_pkg::stat_t stat,
  output ldsbp_pkg::cmd_t  cmd
);
  import ldsbp_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        cmd.decode = 1'b1;
        if (stat.need_wr2) begin
          state_next = S_WR2;
        end else if (stat.need_flush) begin
          state_next = S_FPRE;
        end else if (stat.has_ev) begin
          state_next = S_EMIT;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_WR2: begin
        cmd.wr2    = 1'b1;
        state_next = S_IDLE;
      end
      // first store read is in flight
      S_FPRE: begin
        state_next = S_FLUSH;
      end
      S_FLUSH: begin
        if (stat.slot_free) begin
          cmd.fl_emit = 1'b1;
          if (stat.fl_end) begin
            state_next = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (stat.slot_free) begin
          cmd.ev_emit = 1'b1;
          if (stat.ev_end) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/ldsbp_dp.sv
// ----------------------------------------------------------------------------
// ldsbp_dp
// parser state, request decode, whitespace store and the output register
// ----------------------------------------------------------------------------
module ldsbp_dp (
  input  logic             clk,
  input  logic             rst,
  input  logic             func,
  input  logic [7:0]       in_byte,
  input  ldsbp_pkg::cmd_t  cmd,
  output ldsbp_pkg::stat_t stat,
  input  logic             out_ready,
  output logic             out_valid,
  output ldsbp_pkg::res_t  res
);
  import ldsbp_pkg::*;

  mode_t               mode, mode_next;
  logic                cr_held, cr_held_next;
  logic                seen, seen_next;
  logic                begun, begun_next;
  logic [SPACE_CW-1:0] count, count_next;
  logic                lost, lost_next;
  logic [2:0]          hold, hold_next;

  logic                item_func;
  logic [7:0]          item_byte;

  logic [7:0]          space_store [SPACE_DEPTH];
  logic                wr_en;
  logic [7:0]          wr_data;
  logic                wr2_ok;
  logic [SPACE_AW-1:0] rd_addr;
  logic [7:0]          rd_data;
  logic [SPACE_CW-1:0] fidx;

  res_t                ev [EV_MAX];
  res_t                ev_next [EV_MAX];
  logic [EV_CW-1:0]    nev, nev_next;
  logic [EV_AW-1:0]    eidx;

  logic                need_wr2, need_flush;
  logic                load;
  res_t                load_res;

  // decode of the latched request against the current parser state
  always_comb begin
    mode_t               m;
    logic [SPACE_CW-1:0] cnt;
    logic [EV_CW-1:0]    n;
    logic                do_plain;
    logic                ps;
    logic [7:0]          b;

    b            = item_byte;
    m            = mode;
    cnt          = count;
    n            = '0;
    do_plain     = 1'b0;
    ps           = 1'b0;
    mode_next    = mode;
    cr_held_next = cr_held;
    seen_next    = seen;
    begun_next   = begun;
    count_next   = count;
    lost_next    = lost;
    hold_next    = hold;
    wr_en        = 1'b0;
    wr_data      = b;
    need_wr2     = 1'b0;
    need_flush   = 1'b0;
    for (int i = 0; i < EV_MAX; i++) begin
      ev_next[i] = '0;
    end

    if (item_func) begin
      ev_next[0] = mk_res(K_MODE, 8'h00, 8'h00, 1'b0, 1'b0, mode == M_IDLE);
      n = EV_CW'(1);
      if (mode == M_IDLE) begin
        mode_next = M_BODY;
        hold_next = '0;
      end
    end else if (mode == M_BODY) begin
      if (hold <= 3'd1) begin
        do_plain = 1'b1;
        ps       = hold[0];
      end else if (hold <= 3'd3) begin
        if (b == CH_DOT) begin
          hold_next = hold + 3'd2;
        end else begin
          if (hold[0]) begin
            ev_next[n[EV_AW-1:0]] = mk_res(K_BODY, CH_CR, CH_CR, 1'b0, 1'b0, 1'b0);
            n = n + EV_CW'(1);
          end
          ev_next[n[EV_AW-1:0]] = mk_res(K_BODY, CH_LF, CH_LF, 1'b0, 1'b0, 1'b0);
          n = n + EV_CW'(1);
          do_plain = 1'b1;
          ps       = 1'b0;
        end
      end else begin
        if (b == CH_LF) begin
          ev_next[n[EV_AW-1:0]] = mk_res(K_BEND, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0);
          n = n + EV_CW'(1);
          mode_next = M_IDLE;
          hold_next = '0;
        end else if (hold <= 3'd5 && b == CH_CR) begin
          hold_next = hold + 3'd2;
        end else begin
          if (hold[0]) begin
            ev_next[n[EV_AW-1:0]] = mk_res(K_BODY, CH_CR, CH_CR, 1'b0, 1'b0, 1'b0);
            n = n + EV_CW'(1);
          end
          ev_next[n[EV_AW-1:0]] = mk_res(K_BODY, CH_LF, CH_LF, 1'b0, 1'b0, 1'b0);
          n = n + EV_CW'(1);
          do_plain = 1'b1;
          ps       = (hold > 3'd5);
        end
      end
      if (do_plain) begin
        if (ps) begin
          if (b == CH_LF) begin
            hold_next = 3'd3;
          end else begin
            ev_next[n[EV_AW-1:0]] = mk_res(K_BODY, CH_CR, CH_CR, 1'b0, 1'b0, 1'b0);
            n = n + EV_CW'(1);
            if (b == CH_CR) begin
              hold_next = 3'd1;
            end else begin
              ev_next[n[EV_AW-1:0]] = mk_res(K_BODY, b, b, 1'b0, 1'b0, 1'b0);
              n = n + EV_CW'(1);
              hold_next = 3'd0;
            end
          end
        end else begin
          if (b == CH_CR) begin
            hold_next = 3'd1;
          end else if (b == CH_LF) begin
            hold_next = 3'd2;
          end else begin
            ev_next[n[EV_AW-1:0]] = mk_res(K_BODY, b, b, 1'b0, 1'b0, 1'b0);
            n = n + EV_CW'(1);
            hold_next = 3'd0;
          end
        end
      end
    end else begin
      if (mode == M_IDLE) begin
        m = M_TAG;
      end
      mode_next = m;
      if (b == CH_LF) begin
        cr_held_next = 1'b0;
        if (seen) begin
          ev_next[0] = mk_res(K_LEND, 8'h00, 8'h00, m == M_TAG, lost, 1'b0);
          n = EV_CW'(1);
          mode_next  = M_IDLE;
          seen_next  = 1'b0;
          begun_next = 1'b0;
          count_next = '0;
          lost_next  = 1'b0;
        end
      end else begin
        // a held cr that is not followed by lf is an ordinary line byte
        if (cr_held) begin
          seen_next = 1'b1;
          if (m == M_TAG) begin
            ev_next[0] = mk_res(K_TAG, CH_CR, CH_CR, 1'b0, 1'b0, 1'b0);
            n = EV_CW'(1);
          end else if (begun) begin
            if (cnt < SPACE_CW'(SPACE_DEPTH)) begin
              wr_en   = 1'b1;
              wr_data = CH_CR;
              cnt     = cnt + SPACE_CW'(1);
            end else begin
              lost_next = 1'b1;
            end
          end
        end
        cr_held_next = (b == CH_CR);
        if (b != CH_CR) begin
          seen_next = 1'b1;
          if (m == M_TAG) begin
            if (b == CH_SP) begin
              mode_next = M_TEXT;
            end else begin
              ev_next[n[EV_AW-1:0]] = mk_res(K_TAG, to_upper(b), b, 1'b0, 1'b0, 1'b0);
              n = n + EV_CW'(1);
            end
          end else if (is_ws(b)) begin
            // leading whitespace of the data is dropped
            if (begun) begin
              if (wr_en) begin
                need_wr2 = 1'b1;
              end else if (cnt < SPACE_CW'(SPACE_DEPTH)) begin
                wr_en   = 1'b1;
                wr_data = b;
                cnt     = cnt + SPACE_CW'(1);
              end else begin
                lost_next = 1'b1;
              end
            end
          end else begin
            ev_next[n[EV_AW-1:0]] = mk_res(K_DATA, b, b, 1'b0, 1'b0, 1'b0);
            n = n + EV_CW'(1);
            begun_next = 1'b1;
            need_flush = (cnt != '0);
          end
        end
        count_next = cnt;
      end
    end
    nev_next = n;
  end

  assign wr2_ok = (count < SPACE_CW'(SPACE_DEPTH));
  assign rd_addr = cmd.fl_emit ? SPACE_AW'(fidx + SPACE_CW'(1)) : SPACE_AW'(fidx);

  assign stat.need_wr2   = need_wr2;
  assign stat.need_flush = need_flush;
  assign stat.has_ev     = (nev_next != '0);
  assign stat.fl_end     = ((fidx + SPACE_CW'(1)) == count);
  assign stat.ev_end     = ((EV_CW'(eidx) + EV_CW'(1)) == nev);
  assign stat.slot_free  = !out_valid || out_ready;

  assign load = cmd.fl_emit || cmd.ev_emit;

  always_comb begin
    if (cmd.fl_emit) begin
      load_res = mk_res(K_DATA, rd_data, rd_data, 1'b0, 1'b0, 1'b0);
    end else begin
      load_res      = ev[eidx];
      load_res.last = stat.ev_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= M_IDLE;
      cr_held   <= 1'b0;
      seen      <= 1'b0;
      begun     <= 1'b0;
      count     <= '0;
      lost      <= 1'b0;
      hold      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.decode) begin
        mode    <= mode_next;
        cr_held <= cr_held_next;
        seen    <= seen_next;
        begun   <= begun_next;
        count   <= count_next;
        lost    <= lost_next;
        hold    <= hold_next;
      end else if (cmd.wr2) begin
        if (wr2_ok) begin
          count <= count + SPACE_CW'(1);
        end else begin
          lost <= 1'b1;
        end
      end else if (cmd.fl_emit && stat.fl_end) begin
        count <= '0;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_func <= func;
      item_byte <= in_byte;
    end
    if (cmd.decode) begin
      ev   <= ev_next;
      nev  <= nev_next;
      eidx <= '0;
      fidx <= '0;
    end
    if (cmd.fl_emit) begin
      fidx <= fidx + SPACE_CW'(1);
    end
    if (cmd.ev_emit) begin
      eidx <= eidx + EV_AW'(1);
    end
    if (load) begin
      res <= load_res;
    end
  end

  // held whitespace store
  always_ff @(posedge clk) begin
    if (cmd.decode && wr_en) begin
      space_store[count[SPACE_AW-1:0]] <= wr_data;
    end else if (cmd.wr2 && wr2_ok) begin
      space_store[count[SPACE_AW-1:0]] <= item_byte;
    end
    rd_data <= space_store[rd_addr];
  end

endmodule

// File: rtl/line_and_dot_stuffed_block_parser_top.sv
// ----------------------------------------------------------------------------
// line_and_dot_stuffed_block_parser_top
// in_ch takes one request at a time: a stream byte (func 0) or a data mode
// request (func 1). out_ch gives the results of each request in order, the
// final one marked by last; a request may give none.
// in_ch.ready is high only while the sequencer is idle: the accept cycle is
// followed by a decode cycle, after which the results go out in order while
// out_ch keeps up. A data byte that releases held whitespace bytes sends them
// out first (one store read ahead); a held cr followed by more whitespace
// needs two store writes.
// A stall on out_ch holds the result in the output register; the sequencer
// waits with the next result, and a request is still taken while the last
// result of the previous one waits.
// rst (synchronous) returns to line mode between items with an empty store;
// no clearing pass is needed.
// ----------------------------------------------------------------------------
module line_and_dot_stuffed_block_parser_top (
  input logic       clk,
  input logic       rst,
  ldsbp_in_if.sink  in_ch,
  ldsbp_out_if.source out_ch
);
  import ldsbp_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  res_t  res;
  logic  res_valid;

  ldsbp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ldsbp_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .func      (in_ch.func),
    .in_byte   (in_ch.in_byte),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (out_ch.ready),
    .out_valid (res_valid),
    .res       (res)
  );

  assign out_ch.valid          = res_valid;
  assign out_ch.kind           = res.kind;
  assign out_ch.out_byte       = res.out_byte;
  assign out_ch.raw_byte       = res.raw_byte;
  assign out_ch.no_separator   = res.no_separator;
  assign out_ch.space_overflow = res.space_overflow;
  assign out_ch.accepted       = res.accepted;
  assign out_ch.last           = res.last;

endmodule

// File: rtl/ldsbp_checker.sv
// ----------------------------------------------------------------------------
// ldsbp_checker
// port-level checks on the parser's result channel, bound to the top level
// ----------------------------------------------------------------------------
`include "line_and_dot_stuffed_block_parser_top_defines.svh"

module ldsbp_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] kind,
  input logic [7:0] out_byte,
  input logic [7:0] raw_byte,
  input logic       no_separator,
  input logic       space_overflow,
  input logic       accepted,
  input logic       last
);
  import ldsbp_pkg::*;

  logic in_take;
  logic stalled;

  assign in_take = in_valid && in_ready;
  assign stalled = out_valid && !out_ready;

  // a stalled result holds
  `LDSBP_ASSERT_NXT(a_out_hold, stalled, out_valid && $stable(kind) && $stable(out_byte) && $stable(last), "stalled result changed")

  // line end flags only on a line end
  `LDSBP_ASSERT_IMP(a_flags_lend, out_valid && kind != K_LEND, !no_separator && !space_overflow, "line end flag on another kind")

  // a mode answer is a single result carrying no byte
  `LDSBP_ASSERT_IMP(a_mode_single, out_valid && kind == K_MODE, last && out_byte == 8'h00 && raw_byte == 8'h00, "bad mode answer")

  // only tag bytes are case converted, accepted only on a mode answer
  `LDSBP_ASSERT_IMP(a_raw_match, out_valid && kind != K_TAG, out_byte == raw_byte && (accepted == 1'b0 || kind == K_MODE) && (in_take == 1'b0 || in_ready), "byte or accept flag mismatch")

endmodule

bind line_and_dot_stuffed_block_parser_top ldsbp_checker u_ldsbp_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .kind           (out_ch.kind),
  .out_byte       (out_ch.out_byte),
  .raw_byte       (out_ch.raw_byte),
  .no_separator   (out_ch.no_separator),
  .space_overflow (out_ch.space_overflow),
  .accepted       (out_ch.accepted),
  .last           (out_ch.last)
);

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb: line and dot-stuffed block parser
// drives stream bytes and data mode requests through the input channel in
// random bursts, predicts every parsed result in a scoreboard and compares
// each one taken from the result channel, which stalls on its own pattern
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import ldsbp_pkg::*;

  // what is held back in data mode while a line break or a dot is undecided
  typedef enum logic [2:0] {
    H_NONE,
    H_CR,
    H_LF,
    H_CRLF,
    H_LF_DOT,
    H_CRLF_DOT,
    H_LF_DOT_CR,
    H_CRLF_DOT_CR
  } hold_t;

  typedef struct packed {
    logic       func;
    logic [7:0] data;
  } req_t;

  class parse_scoreboard;
    mode_t       mode;
    bit          cr_held;
    bit          line_seen;
    bit          data_begun;
    bit          space_lost;
    logic [7:0]  blank_store [SPACE_DEPTH];
    int unsigned blank_count;
    hold_t       hold;
    res_t        step_results[$];
    res_t        expected_results[$];
    int          mismatches;
    int          checked;
    int          line_ends;
    int          overflow_ends;
    int          body_ends;
    int          mode_reqs;
    int          mode_grants;

    function new();
      mode        = M_IDLE;
      cr_held     = 1'b0;
      line_seen   = 1'b0;
      data_begun  = 1'b0;
      space_lost  = 1'b0;
      blank_count = 0;
      hold        = H_NONE;
    endfunction

    static function logic is_blank(logic [7:0] b);
      return b == CH_SP || b == CH_TAB || b == CH_LF || b == CH_VT ||
             b == CH_FF || b == CH_CR;
    endfunction

    function logic [7:0] fold_upper(logic [7:0] b);
      if (b >= 8'h61 && b <= 8'h7A)
        return b - 8'h20;
      return b;
    endfunction

    function void add_result(logic [2:0] kind, logic [7:0] ob, logic [7:0] rb,
                             logic nosep, logic ovf, logic acc);
      res_t r;
      r.kind           = kind;
      r.out_byte       = ob;
      r.raw_byte       = rb;
      r.no_separator   = nosep;
      r.space_overflow = ovf;
      r.accepted       = acc;
      r.last           = 1'b0;
      step_results.push_back(r);
    endfunction

    function void take_line_byte(logic [7:0] b);
      line_seen = 1'b1;
      if (mode == M_TAG) begin
        if (b == CH_SP)
          mode = M_TEXT;
        else
          add_result(K_TAG, fold_upper(b), b, 1'b0, 1'b0, 1'b0);
        return;
      end
      if (is_blank(b)) begin
        // leading whitespace never reaches the store
        if (!data_begun)
          return;
        if (blank_count < SPACE_DEPTH) begin
          blank_store[blank_count] = b;
          blank_count++;
        end else begin
          space_lost = 1'b1;
        end
        return;
      end
      for (int i = 0; i < blank_count; i++)
        add_result(K_DATA, blank_store[i], blank_store[i], 1'b0, 1'b0, 1'b0);
      blank_count = 0;
      add_result(K_DATA, b, b, 1'b0, 1'b0, 1'b0);
      data_begun = 1'b1;
    endfunction

    function void take_line_step(logic [7:0] b);
      if (b == CH_LF) begin
        cr_held = 1'b0;
        if (!line_seen)
          return;
        add_result(K_LEND, 8'h00, 8'h00, mode == M_TAG, space_lost, 1'b0);
        line_ends++;
        if (space_lost)
          overflow_ends++;
        mode        = M_IDLE;
        line_seen   = 1'b0;
        data_begun  = 1'b0;
        blank_count = 0;
        space_lost  = 1'b0;
        return;
      end
      // a cr not followed by lf is an ordinary byte
      if (cr_held) begin
        cr_held = 1'b0;
        take_line_byte(CH_CR);
      end
      if (b == CH_CR)
        cr_held = 1'b1;
      else
        take_line_byte(b);
    endfunction

    function void emit_body(logic [7:0] b);
      add_result(K_BODY, b, b, 1'b0, 1'b0, 1'b0);
    endfunction

    function void body_plain(logic [7:0] b);
      if (hold == H_CR) begin
        if (b == CH_LF) begin
          hold = H_CRLF;
          return;
        end
        emit_body(CH_CR);
        if (b == CH_CR)
          return;
        emit_body(b);
        hold = H_NONE;
        return;
      end
      if (b == CH_CR)
        hold = H_CR;
      else if (b == CH_LF)
        hold = H_LF;
      else
        emit_body(b);
    endfunction

    function void flush_break();
      if (hold == H_CRLF || hold == H_CRLF_DOT || hold == H_CRLF_DOT_CR)
        emit_body(CH_CR);
      emit_body(CH_LF);
    endfunction

    function void take_body_byte(logic [7:0] b);
      case (hold)
        H_NONE, H_CR: begin
          body_plain(b);
        end
        H_LF, H_CRLF: begin
          // dot right after a line break: dropped unless it ends the body
          if (b == CH_DOT) begin
            hold = (hold == H_LF) ? H_LF_DOT : H_CRLF_DOT;
            return;
          end
          flush_break();
          hold = H_NONE;
          body_plain(b);
        end
        default: begin
          if (b == CH_LF) begin
            add_result(K_BEND, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0);
            body_ends++;
            mode = M_IDLE;
            hold = H_NONE;
            return;
          end
          if ((hold == H_LF_DOT || hold == H_CRLF_DOT) && b == CH_CR) begin
            hold = (hold == H_LF_DOT) ? H_LF_DOT_CR : H_CRLF_DOT_CR;
            return;
          end
          flush_break();
          // a cr after the dot stays held as a possible line break
          hold = (hold == H_LF_DOT || hold == H_CRLF_DOT) ? H_NONE : H_CR;
          body_plain(b);
        end
      endcase
    endfunction

    function void note_request(logic f, logic [7:0] b);
      res_t r;
      step_results.delete();
      if (f) begin
        mode_reqs++;
        if (mode == M_IDLE) begin
          mode = M_BODY;
          hold = H_NONE;
          mode_grants++;
          add_result(K_MODE, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1);
        end else begin
          add_result(K_MODE, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0);
        end
      end else if (mode == M_BODY) begin
        take_body_byte(b);
      end else begin
        if (mode == M_IDLE)
          mode = M_TAG;
        take_line_step(b);
      end
      if (step_results.size() > 0) begin
        r = step_results.pop_back();
        r.last = 1'b1;
        step_results.push_back(r);
      end
      foreach (step_results[i])
        expected_results.push_back(step_results[i]);
    endfunction

    function string describe(res_t r);
      return $sformatf("kind %0d out %02h raw %02h nosep %0b ovf %0b acc %0b last %0b",
                       r.kind, r.out_byte, r.raw_byte, r.no_separator,
                       r.space_overflow, r.accepted, r.last);
    endfunction

    function void check_result(res_t got);
      res_t want;
      bit   bad;
      checked++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: %s", describe(got));
        return;
      end
      want = expected_results.pop_front();
      bad = (got.kind !== want.kind) || (got.out_byte !== want.out_byte) ||
            (got.raw_byte !== want.raw_byte) ||
            (got.no_separator !== want.no_separator) ||
            (got.space_overflow !== want.space_overflow) ||
            (got.accepted !== want.accepted) || (got.last !== want.last);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch at result %0d", checked);
          $display("  expected %s", describe(want));
          $display("  actual   %s", describe(got));
        end
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  ldsbp_in_if  in_ch ();
  ldsbp_out_if out_ch ();

  line_and_dot_stuffed_block_parser_top DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  parse_scoreboard sb;
  req_t            req_q[$];
  int              reqs_sent;
  bit              pressure_done;

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #400000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function void queue_req(logic f, logic [7:0] b);
    req_t r;
    r.func = f;
    r.data = b;
    req_q.push_back(r);
  endfunction

  function void queue_byte(logic [7:0] b);
    queue_req(1'b0, b);
  endfunction

  function void queue_blank_run(int n);
    logic [7:0] b;
    repeat (n) begin
      case ($urandom_range(0, 4))
        0: b = CH_TAB;
        1: b = CH_VT;
        2: b = CH_FF;
        3: b = CH_CR;
        default: b = CH_SP;
      endcase
      queue_byte(b);
    end
  endfunction

  function void queue_break();
    if ($urandom_range(0, 1))
      queue_byte(CH_CR);
    queue_byte(CH_LF);
  endfunction

  function logic [7:0] rand_tag_byte();
    logic [7:0] b;
    if ($urandom_range(0, 1))
      return 8'(8'h41 + $urandom_range(0, 25) + ($urandom_range(0, 1) ? 8'h20 : 8'h00));
    do
      b = 8'($urandom);
    while (b == CH_SP || b == CH_LF);
    return b;
  endfunction

  function logic [7:0] rand_word_byte();
    logic [7:0] b;
    do
      b = 8'($urandom);
    while (parse_scoreboard::is_blank(b));
    return b;
  endfunction

  function void gen_line(bit force_ovf);
    bit no_sep;
    int tag_len;
    int words;
    int run;
    if ($urandom_range(0, 5) == 0)
      queue_break();
    no_sep  = !force_ovf && ($urandom_range(0, 3) == 0);
    tag_len = no_sep ? $urandom_range(1, 5) : $urandom_range(0, 4);
    repeat (tag_len) queue_byte(rand_tag_byte());
    if (!no_sep) begin
      queue_byte(CH_SP);
      queue_blank_run($urandom_range(0, 2));
      words = force_ovf ? 2 : $urandom_range(0, 3);
      for (int w = 0; w < words; w++) begin
        if (w > 0) begin
          if (force_ovf)
            run = $urandom_range(SPACE_DEPTH + 1, SPACE_DEPTH + 4);
          else if ($urandom_range(0, 7) == 0)
            run = $urandom_range(SPACE_DEPTH - 1, SPACE_DEPTH + 3);
          else
            run = $urandom_range(1, 3);
          queue_blank_run(run);
        end
        repeat ($urandom_range(1, 4)) queue_byte(rand_word_byte());
      end
      queue_blank_run($urandom_range(0, 3));
    end
    if ($urandom_range(0, 9) == 0)
      queue_req(1'b1, 8'($urandom));
    queue_break();
  endfunction

  function void gen_body();
    int         lines;
    int         len;
    logic [7:0] b;
    queue_req(1'b1, 8'($urandom));
    lines = $urandom_range(0, 3);
    // the end marker needs a line break in front of it
    if (lines == 0)
      queue_break();
    repeat (lines) begin
      if ($urandom_range(0, 3) == 0) begin
        queue_byte(CH_DOT);
        queue_byte(CH_DOT);
      end
      len = $urandom_range(0, 6);
      for (int i = 0; i < len; i++) begin
        do
          b = 8'($urandom);
        while (b == CH_LF);
        // a dot opening a line is stuffed so that it cannot end the body
        if (i == 0 && b == CH_DOT)
          queue_byte(CH_DOT);
        queue_byte(b);
      end
      if ($urandom_range(0, 11) == 0)
        queue_req(1'b1, 8'($urandom));
      queue_break();
    end
    queue_byte(CH_DOT);
    queue_break();
  endfunction

  function void gen_noise();
    repeat ($urandom_range(3, 10)) begin
      if ($urandom_range(0, 7) == 0)
        queue_req(1'b1, 8'($urandom));
      else
        queue_byte(8'($urandom));
    end
    // closes a body or a line from any state, back to idle
    queue_byte(CH_LF);
    queue_byte(CH_DOT);
    queue_byte(CH_LF);
  endfunction

  function void build_directed();
    queue_byte(CH_LF);              // empty line, skipped
    queue_req(1'b1, 8'h00);         // refused after a skipped empty line
    queue_byte(8'h61);              // lower-case tag byte
    queue_byte(8'hFF);
    queue_byte(8'h00);
    queue_byte(CH_SP);
    queue_byte(CH_TAB);             // leading data whitespace
    queue_byte(8'h78);
    queue_byte(CH_CR);              // lone cr inside the data
    queue_byte(8'h79);
    queue_byte(CH_SP);
    queue_req(1'b1, 8'hFF);         // refused mid-line
    queue_byte(CH_CR);
    queue_byte(CH_LF);
    queue_byte(8'h7A);
    queue_byte(CH_CR);              // lone cr in the tag
    queue_byte(CH_CR);
    queue_byte(CH_LF);              // line with no separator
    queue_req(1'b1, 8'h00);
    queue_byte(CH_DOT);             // dot at body start is kept
    queue_byte(CH_LF);
    queue_byte(CH_DOT);
    queue_byte(CH_DOT);
    queue_byte(CH_CR);
    queue_byte(CH_LF);
    queue_byte(CH_DOT);
    queue_byte(CH_CR);
    queue_byte(CH_LF);
  endfunction

  task automatic send_req(req_t r);
    in_ch.valid   <= 1'b1;
    in_ch.func    <= r.func;
    in_ch.in_byte <= r.func ? 8'($urandom) : r.data;
    do
      @(posedge clk);
    while (in_ch.ready !== 1'b1);
    sb.note_request(r.func, r.func ? 8'h00 : r.data);
    reqs_sent++;
  endtask

  task automatic drain_requests();
    int   burst_left;
    int   gap;
    req_t r;
    burst_left = 0;
    while (req_q.size() > 0) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          in_ch.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      r = req_q.pop_front();
      send_req(r);
      burst_left--;
    end
    in_ch.valid <= 1'b0;
  endtask

  initial begin
    int target;
    sb            = new();
    rst           = 1'b1;
    in_ch.valid   = 1'b0;
    in_ch.func    = 1'b0;
    in_ch.in_byte = 8'h00;
    build_directed();
    target = 170;
    gen_line(1'b1);
    while (req_q.size() < target) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: gen_line(1'b0);
        6, 7, 8: gen_body();
        default: gen_noise();
      endcase
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    drain_requests();
    while (sb.pending() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    $display("covered %0d requests, %0d of them data mode requests (%0d granted), %0d results",
             reqs_sent, sb.mode_reqs, sb.mode_grants, sb.checked);
    $display("line ends %0d (%0d with whitespace overflow), body ends %0d, mismatches %0d",
             sb.line_ends, sb.overflow_ends, sb.body_ends, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // receiver: stall patterns that change now and then, one long hold-off
  initial begin
    int         phase_left;
    int         stall_style;
    logic [7:0] stall_mask;
    int         tick;
    out_ch.ready = 1'b0;
    phase_left   = 0;
    stall_style  = 0;
    stall_mask   = 8'hFF;
    tick         = 0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      @(posedge clk);
      if (!pressure_done && reqs_sent >= 60) begin
        pressure_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (150) @(posedge clk);
      end
      if (phase_left == 0) begin
        stall_style = $urandom_range(0, 2);
        stall_mask  = 8'($urandom) | 8'h01;
        phase_left  = $urandom_range(20, 100);
      end
      phase_left--;
      tick++;
      case (stall_style)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= stall_mask[tick % 8];
        default: out_ch.ready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    res_t got;
    if (rst === 1'b0 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got.kind           = out_ch.kind;
      got.out_byte       = out_ch.out_byte;
      got.raw_byte       = out_ch.raw_byte;
      got.no_separator   = out_ch.no_separator;
      got.space_overflow = out_ch.space_overflow;
      got.accepted       = out_ch.accepted;
      got.last           = out_ch.last;
      sb.check_result(got);
    end
  end

endmodule
